// ===== rtl/core/nsqm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nsqm_pkg;
    localparam int MaxContainers = 16;
    localparam int Depth         = 64;
    localparam int ValueBits     = 64;
    localparam int NameBits      = 64;

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_PUSH   = 2'd1,
        REQ_POP    = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_CREATED = 3'd0,
        ST_PUSHED  = 3'd1,
        ST_POPPED  = 3'd2,
        ST_EXISTS  = 3'd3,
        ST_NO_NAME = 3'd4,
        ST_EMPTY   = 3'd5,
        ST_IGNORED = 3'd6,
        ST_FULL    = 3'd7
    } t_status;

    localparam logic [7:0] CharI = 8'h69;
    localparam logic [7:0] CharD = 8'h64;
    localparam logic [7:0] CharS = 8'h73;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] name_key;
        logic        make_queue;
        logic [63:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] popped_value;
    } t_out_item;
endpackage
`default_nettype wire

// ===== rtl/core/nsqm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nsqm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/nsqm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Front: classifies a request against the slot table and updates the table.
// Emits one command per item into a two-entry queue toward the back.
module nsqm_front #(
    parameter int MAX_CONTAINERS = nsqm_pkg::MaxContainers,
    parameter int DEPTH          = nsqm_pkg::Depth,
    parameter int VALUE_BITS     = nsqm_pkg::ValueBits,
    parameter int NAME_BITS      = nsqm_pkg::NameBits,
    parameter int SW = (MAX_CONTAINERS > 1) ? $clog2(MAX_CONTAINERS) : 1,
    parameter int PW = $clog2(DEPTH)
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire  nsqm_pkg::t_in_item  i_item,
    output logic                      o_cmd_valid,
    input  wire                       i_cmd_stall,
    output logic [2:0]                o_cmd_status,
    output logic                      o_cmd_we,
    output logic                      o_cmd_re,
    output logic [SW+PW-1:0]          o_cmd_addr,
    output logic [VALUE_BITS-1:0]     o_cmd_value
);
    import nsqm_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [NAME_BITS-1:0] r_keys  [MAX_CONTAINERS];
    logic [MAX_CONTAINERS-1:0] r_in_use, r_is_queue;
    logic [PW-1:0] r_front [MAX_CONTAINERS];
    logic [CW-1:0] r_fill  [MAX_CONTAINERS];

    // Command queue: two entries
    typedef struct packed {
        logic [2:0]            status;
        logic                  we;
        logic                  re;
        logic [SW+PW-1:0]      addr;
        logic [VALUE_BITS-1:0] value;
    } t_cmd;
    t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;

    logic [NAME_BITS-1:0] key;
    logic [7:0]           first;
    logic                 hit, free_ok, accept, pop_q;
    logic [SW-1:0]        hit_idx, free_idx;
    t_cmd                 cmd;
    logic [PW-1:0]        pos;
    logic [PW:0]          qsum;

    assign key   = i_item.name_key[NAME_BITS-1:0];
    assign first = key[NAME_BITS-1 -: 8];

    always_comb begin
        hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
        for (int k = MAX_CONTAINERS - 1; k >= 0; k--) begin
            if (r_in_use[k] && r_keys[k] == key) begin
                hit = 1'b1; hit_idx = SW'(k);
            end
            if (!r_in_use[k]) begin
                free_ok = 1'b1; free_idx = SW'(k);
            end
        end
    end

    assign o_stall = (r_cnt == 2'd2);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        qsum = {1'b0, r_front[hit_idx]} + PW'(r_fill[hit_idx]);
        if (r_is_queue[hit_idx]) begin
            pos = (qsum >= (PW+1)'(DEPTH)) ? PW'(qsum - (PW+1)'(DEPTH)) : qsum[PW-1:0];
        end else begin
            pos = (r_front[hit_idx] == '0) ? PW'(DEPTH - 1) : r_front[hit_idx] - 1'b1;
        end
        cmd = '0;
        cmd.value  = i_item.push_value[VALUE_BITS-1:0];
        cmd.status = ST_IGNORED;
        if ((first == CharI || first == CharD || first == CharS)
            && i_item.req_type != REQ_NONE) begin
            case (i_item.req_type)
                REQ_CREATE: cmd.status = hit ? ST_EXISTS : (free_ok ? ST_CREATED : ST_FULL);
                REQ_PUSH: begin
                    if (!hit) cmd.status = ST_NO_NAME;
                    else if (r_fill[hit_idx] >= CW'(DEPTH)) cmd.status = ST_FULL;
                    else begin
                        cmd.status = ST_PUSHED; cmd.we = 1'b1;
                        cmd.addr = {hit_idx, pos};
                    end
                end
                REQ_POP: begin
                    if (!hit) cmd.status = ST_NO_NAME;
                    else if (r_fill[hit_idx] == '0) cmd.status = ST_EMPTY;
                    else begin
                        cmd.status = ST_POPPED; cmd.re = 1'b1;
                        cmd.addr = {hit_idx, r_front[hit_idx]};
                    end
                end
                default: cmd.status = ST_IGNORED;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr] <= cmd;
            if (cmd.status == ST_CREATED) begin
                r_keys[free_idx] <= key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0; r_is_queue <= '0;
            for (int k = 0; k < MAX_CONTAINERS; k++) begin
                r_front[k] <= '0; r_fill[k] <= '0;
            end
            r_cnt <= '0; r_rd <= 1'b0; r_wr <= 1'b0;
        end else begin
            if (accept) begin
                r_wr <= ~r_wr;
                case (cmd.status)
                    ST_CREATED: begin
                        r_in_use[free_idx]   <= 1'b1;
                        r_is_queue[free_idx] <= i_item.make_queue;
                        r_front[free_idx]    <= '0;
                        r_fill[free_idx]     <= '0;
                    end
                    ST_PUSHED: begin
                        if (!r_is_queue[hit_idx]) r_front[hit_idx] <= pos;
                        r_fill[hit_idx] <= r_fill[hit_idx] + 1'b1;
                    end
                    ST_POPPED: begin
                        r_front[hit_idx] <= (r_front[hit_idx] == PW'(DEPTH - 1))
                            ? '0 : r_front[hit_idx] + 1'b1;
                        r_fill[hit_idx] <= r_fill[hit_idx] - 1'b1;
                    end
                    default: ;
                endcase
            end
            if (pop_q) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(accept) - 2'(pop_q);
        end
    end

    assign o_cmd_valid  = (r_cnt != 2'd0);
    assign pop_q        = o_cmd_valid && !i_cmd_stall;
    assign o_cmd_status = r_q[r_rd].status;
    assign o_cmd_we     = r_q[r_rd].we;
    assign o_cmd_re     = r_q[r_rd].re;
    assign o_cmd_addr   = r_q[r_rd].addr;
    assign o_cmd_value  = r_q[r_rd].value;

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_nostall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !o_stall) else $error("stall while empty");
    a_pop_then_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_q && !accept |=> !o_stall) else $error("stall after drain");
endmodule
`default_nettype wire

// ===== rtl/core/nsqm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Back: performs the storage access and holds the result register.
module nsqm_back #(
    parameter int MAX_CONTAINERS = nsqm_pkg::MaxContainers,
    parameter int DEPTH          = nsqm_pkg::Depth,
    parameter int VALUE_BITS     = nsqm_pkg::ValueBits,
    parameter int SW = (MAX_CONTAINERS > 1) ? $clog2(MAX_CONTAINERS) : 1,
    parameter int PW = $clog2(DEPTH)
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cmd_valid,
    output logic                      o_cmd_stall,
    input  wire  [2:0]                i_cmd_status,
    input  wire                       i_cmd_we,
    input  wire                       i_cmd_re,
    input  wire  [SW+PW-1:0]          i_cmd_addr,
    input  wire  [VALUE_BITS-1:0]     i_cmd_value,
    output logic                      o_valid,
    input  wire                       i_stall,
    output nsqm_pkg::t_out_item       o_item
);
    import nsqm_pkg::*;

    localparam int AW = SW + PW;

    logic       r_busy, r_is_rd, r_valid;
    logic [2:0] r_status, r_out_status;
    logic [VALUE_BITS-1:0] r_out_val, rdata;
    logic       take;

    // One command in flight; it waits in the access stage until the result
    // register is free.
    assign o_cmd_stall = r_busy;
    assign take = i_cmd_valid && !r_busy;

    nsqm_ram #(.WIDTH(VALUE_BITS), .DEPTH(1 << AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (take && i_cmd_we),
        .i_waddr(i_cmd_addr),
        .i_wdata(i_cmd_value),
        .i_re   (take && i_cmd_re),
        .i_raddr(i_cmd_addr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status <= i_cmd_status;
            r_is_rd  <= i_cmd_re;
        end
        if (r_busy && (!r_valid || !i_stall)) begin
            r_out_status <= r_status;
            r_out_val    <= r_is_rd ? rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_valid <= 1'b0;
        end else begin
            if (r_busy && (!r_valid || !i_stall)) begin
                r_busy <= 1'b0; r_valid <= 1'b1;
            end else begin
                if (take) r_busy <= 1'b1;
                if (r_valid && !i_stall) r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    always_comb begin
        o_item = '0;
        o_item.status = r_out_status;
        o_item.popped_value[VALUE_BITS-1:0] = r_out_val;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid) else $error("result lost");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_busy) else $error("command not latched");
    a_val_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out_status != ST_POPPED |-> r_out_val == '0)
        else $error("nonzero value");
endmodule
`default_nettype wire

// ===== rtl/core/named_stack_queue_manager.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Named stack/queue manager. Create, push and pop requests name a container by
// a packed key; each request gives exactly one result transfer (status, and the
// word on a successful pop). The front stage matches the key against all slots
// combinationally and updates the slot table; the back stage does the single
// storage access and registers the result. An accepted item passes through the
// two-entry command queue, the one-deep access stage and the result register,
// and the access stage takes no new command while it still holds one.
module named_stack_queue_manager #(
    parameter int MAX_CONTAINERS = nsqm_pkg::MaxContainers,
    parameter int DEPTH          = nsqm_pkg::Depth,
    parameter int VALUE_BITS     = nsqm_pkg::ValueBits,
    parameter int NAME_BITS      = nsqm_pkg::NameBits
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire  nsqm_pkg::t_in_item  i_item,
    output logic                      o_valid,
    input  wire                       i_stall,
    output nsqm_pkg::t_out_item       o_item
);
    import nsqm_pkg::*;

    localparam int SW = (MAX_CONTAINERS > 1) ? $clog2(MAX_CONTAINERS) : 1;
    localparam int PW = $clog2(DEPTH);

    logic                  cmd_valid, cmd_stall, cmd_we, cmd_re;
    logic [2:0]            cmd_status;
    logic [SW+PW-1:0]      cmd_addr;
    logic [VALUE_BITS-1:0] cmd_value;

    nsqm_front #(.MAX_CONTAINERS(MAX_CONTAINERS), .DEPTH(DEPTH),
        .VALUE_BITS(VALUE_BITS), .NAME_BITS(NAME_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_cmd_valid(cmd_valid), .i_cmd_stall(cmd_stall),
        .o_cmd_status(cmd_status), .o_cmd_we(cmd_we), .o_cmd_re(cmd_re),
        .o_cmd_addr(cmd_addr), .o_cmd_value(cmd_value)
    );

    nsqm_back #(.MAX_CONTAINERS(MAX_CONTAINERS), .DEPTH(DEPTH),
        .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .o_cmd_stall(cmd_stall), .i_cmd_status(cmd_status), .i_cmd_we(cmd_we),
        .i_cmd_re(cmd_re), .i_cmd_addr(cmd_addr), .i_cmd_value(cmd_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );
endmodule
`default_nettype wire

// ===== tb/nsqm_checker.sv =====
`timescale 1ns / 1ps
module nsqm_checker (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire                      i_in_stall,
    input  wire  nsqm_pkg::t_in_item i_in_item,
    input  wire                      i_out_valid,
    input  wire                      i_out_stall,
    input  wire  nsqm_pkg::t_out_item i_out_item,
    output int                       o_fail_count,
    output int                       o_pending
);
    import nsqm_pkg::*;

    logic [NameBits-1:0]  slot_name [MaxContainers];
    logic                 slot_used [MaxContainers];
    logic                 slot_fifo [MaxContainers];
    logic [5:0]           slot_front [MaxContainers];
    logic [6:0]           slot_fill [MaxContainers];
    logic [ValueBits-1:0] words [MaxContainers][Depth];

    t_out_item expected_results[$];
    int        fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic t_out_item apply_request(t_in_item it);
        t_out_item r;
        logic [7:0] first;
        int slot;
        int free_slot;
        logic [5:0] pos;
        r.status = ST_IGNORED;
        r.popped_value = '0;
        first = it.name_key[NameBits-1 -: 8];
        slot = -1;
        free_slot = -1;
        if ((first == CharI || first == CharD || first == CharS)
                && t_req'(it.req_type) != REQ_NONE) begin
            for (int k = MaxContainers - 1; k >= 0; k--) begin
                if (slot_used[k] && slot_name[k] == it.name_key) slot = k;
                if (!slot_used[k]) free_slot = k;
            end
            if (t_req'(it.req_type) == REQ_CREATE) begin
                if (slot >= 0) begin
                    r.status = ST_EXISTS;
                end else if (free_slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    slot_used[free_slot] = 1'b1;
                    slot_fifo[free_slot] = it.make_queue;
                    slot_name[free_slot] = it.name_key;
                    slot_front[free_slot] = '0;
                    slot_fill[free_slot] = '0;
                    r.status = ST_CREATED;
                end
            end else if (slot < 0) begin
                r.status = ST_NO_NAME;
            end else if (t_req'(it.req_type) == REQ_PUSH) begin
                if (slot_fill[slot] >= Depth) begin
                    r.status = ST_FULL;
                end else begin
                    if (slot_fifo[slot]) begin
                        pos = slot_front[slot] + slot_fill[slot][5:0];
                    end else begin
                        pos = slot_front[slot] - 6'd1;
                        slot_front[slot] = pos;
                    end
                    words[slot][pos] = it.push_value;
                    slot_fill[slot]++;
                    r.status = ST_PUSHED;
                end
            end else if (slot_fill[slot] == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.popped_value = words[slot][slot_front[slot]];
                slot_front[slot]++;
                slot_fill[slot]--;
                r.status = ST_POPPED;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < MaxContainers; k++) begin
                slot_used[k] = 1'b0;
                slot_fifo[k] = 1'b0;
                slot_front[k] = '0;
                slot_fill[k] = '0;
            end
            expected_results.delete();
        end
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            expected_results.push_back(apply_request(i_in_item));
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                fail_total++;
                if (fail_total <= 10)
                    $display("unexpected result: status %0d value %h",
                             i_out_item.status, i_out_item.popped_value);
            end else begin
                want = expected_results.pop_front();
                if (want.status !== i_out_item.status
                        || want.popped_value !== i_out_item.popped_value) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("mismatch: expected %0d/%h got %0d/%h",
                                 want.status, want.popped_value,
                                 i_out_item.status, i_out_item.popped_value);
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import nsqm_pkg::*;

    localparam int CycleLimit = 200000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;

    logic [NameBits-1:0] name_pool [24];
    t_in_item            script[$];

    named_stack_queue_manager dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_item(in_item), .o_valid(out_valid), .i_stall(out_stall), .o_item(out_item)
    );

    nsqm_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stall: phases of none, light and heavy back-pressure.
    always @(posedge clk) begin
        case ((cycle_count / 300) % 3)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_in_item make_req(t_req r, logic [NameBits-1:0] key,
                                          logic q, logic [ValueBits-1:0] v);
        t_in_item it;
        it.req_type = r;
        it.name_key = key;
        it.make_queue = q;
        it.push_value = v;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send(t_in_item it);
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Bursts of transfers separated by random gaps.
    task automatic send_all();
        int burst;
        burst = 0;
        while (script.size() > 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 1)) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            send(script.pop_front());
            burst--;
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        logic [NameBits-1:0] key;
        int pick;
        int r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        for (int k = 0; k < 24; k++) begin
            name_pool[k] = rand64();
            case (k % 3)
                0: name_pool[k][63:56] = CharI;
                1: name_pool[k][63:56] = CharD;
                default: name_pool[k][63:56] = CharS;
            endcase
        end
        name_pool[0] = {CharS, 56'h0};
        name_pool[1] = {CharI, {56{1'b1}}};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unknown names, bad characters, spare code, stack and queue order.
        script.push_back(make_req(REQ_POP, name_pool[0], 1'b0, '0));
        script.push_back(make_req(REQ_PUSH, name_pool[0], 1'b0, '1));
        script.push_back(make_req(REQ_CREATE, {8'h78, 56'h0}, 1'b0, '0));
        script.push_back(make_req(REQ_CREATE, '1, 1'b1, '1));
        script.push_back(make_req(REQ_NONE, name_pool[0], 1'b1, '1));
        script.push_back(make_req(REQ_CREATE, name_pool[0], 1'b0, '0));
        script.push_back(make_req(REQ_CREATE, name_pool[0], 1'b1, '0));
        script.push_back(make_req(REQ_CREATE, name_pool[1], 1'b1, '0));
        script.push_back(make_req(REQ_POP, name_pool[0], 1'b0, '0));
        script.push_back(make_req(REQ_PUSH, name_pool[0], 1'b0, '1));
        script.push_back(make_req(REQ_PUSH, name_pool[0], 1'b0, 64'h5555_aaaa_0000_ffff));
        script.push_back(make_req(REQ_PUSH, name_pool[1], 1'b0, '0));
        script.push_back(make_req(REQ_PUSH, name_pool[1], 1'b0, 64'h1));
        script.push_back(make_req(REQ_POP, name_pool[0], 1'b0, '0));
        script.push_back(make_req(REQ_POP, name_pool[0], 1'b0, '0));
        script.push_back(make_req(REQ_POP, name_pool[1], 1'b0, '0));
        script.push_back(make_req(REQ_POP, name_pool[1], 1'b0, '0));
        script.push_back(make_req(REQ_POP, name_pool[1], 1'b0, '0));
        send_all();

        // Fill one stack and one queue to overflow, then drain past empty.
        for (int k = 0; k < 66; k++)
            script.push_back(make_req(REQ_PUSH, name_pool[k % 2], 1'b0, rand64()));
        for (int k = 0; k < 66; k++)
            script.push_back(make_req(REQ_PUSH, name_pool[k % 2], 1'b0, rand64()));
        for (int k = 0; k < 134; k++)
            script.push_back(make_req(REQ_POP, name_pool[k % 2], 1'b0, '0));
        send_all();

        // Random: mostly valid names from the pool; creates overflow the table.
        for (int n = 0; n < 470; n++) begin
            pick = $urandom_range(0, 23);
            key = name_pool[pick];
            r = $urandom_range(0, 99);
            if (r < 4) key = rand64();
            else if (r < 6) key[$urandom_range(0, 55)] ^= 1'b1;
            r = $urandom_range(0, 99);
            script.push_back(make_req(t_req'(r < 15 ? REQ_CREATE : r < 60 ? REQ_PUSH :
                                              r < 97 ? REQ_POP : REQ_NONE),
                                      key, 1'($urandom_range(0, 1)), rand64()));
        end
        send_all();
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
